[rtl/ihex_pkg.sv]
// Shared types and constants for the Intel HEX record parser.
package ihex_pkg;

    // Parser phase within the character stream.
    typedef enum logic [3:0] {
        PH_COLON   = 4'd0,
        PH_COUNT   = 4'd1,
        PH_ADDR    = 4'd2,
        PH_TYPE    = 4'd3,
        PH_DATA    = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_CHECK   = 4'd6,
        PH_SKIP    = 4'd7,
        PH_STOPPED = 4'd8,
        PH_DONE    = 4'd9
    } phase_t;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_REC_OK    = 3'd1,
        KIND_SUM_WARN  = 3'd2,
        KIND_END       = 3'd3,
        KIND_FORMAT    = 3'd4,
        KIND_BAD_TYPE  = 3'd5,
        KIND_SUM_FATAL = 3'd6
    } kind_t;

    // Record kind held while the payload is parsed.
    typedef enum logic [1:0] {
        REC_DATA       = 2'd0,
        REC_EXT_LINEAR = 2'd1,
        REC_START      = 2'd2
    } rec_kind_t;

    localparam logic [7:0] CHAR_COLON      = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] TYPE_DATA       = 8'h00;
    localparam logic [7:0] TYPE_EXT_LINEAR = 8'h04;
    localparam logic [7:0] TYPE_START      = 8'h05;
    localparam logic [7:0] ADDR_BYTES      = 8'd2;
    localparam logic [7:0] EXT_BYTES       = 8'd2;
    localparam logic [7:0] START_BYTES     = 8'd4;

    // Hex digit decode; an invalid digit reads as zero.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            n = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            n = 4'(c - 8'h37);
        end
        return n;
    endfunction

    function automatic logic hex_valid(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

endpackage

[rtl/intel_hex_record_parser_core.sv]
// Intel HEX record parser: one character per word in, at most one result per word out.
// Results are registered: a result enters the output register when its character is accepted.
// Throughput: one character per cycle; in_ready drops only while a result waits untaken.
// Each character is decoded and applied to the parser state in the cycle it is accepted.
// Reset (rst_n low, asynchronous) returns to the expect-colon phase with all parser state cleared.
// After an end record or a halting error, characters are still taken but give no result until reset.
module intel_hex_record_parser_core
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [31:0] address,
    output logic [7:0]  data_byte,
    output logic [7:0]  computed_sum,
    output logic [31:0] start_address,
    output logic        start_valid,
    output logic        bad_hex
);

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        digit_half_reg, digit_half_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    rec_kind_t   rec_kind_reg, rec_kind_next;
    logic [15:0] load_addr_reg, load_addr_next;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [15:0] base_upper_reg, base_upper_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [31:0] payload_shift_reg, payload_shift_next;
    logic [31:0] start_addr_reg, start_addr_next;
    logic        start_seen_reg, start_seen_next;
    logic        bad_hex_seen_reg, bad_hex_seen_next;
    logic        fatal_reg;

    // Output register.
    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [31:0] address_reg;
    logic [7:0]  data_reg;
    logic [7:0]  sum_reg;
    logic [31:0] start_out_reg;
    logic        start_valid_reg;
    logic        bad_hex_reg;

    // Per-character decode.
    logic        in_accept;
    logic        in_record;
    logic        is_newline;
    logic        decode_active;
    logic [3:0]  nib;
    logic [7:0]  cur_byte;
    logic        cur_bad;
    logic [7:0]  calc_sum;
    logic [7:0]  index_inc;
    logic [31:0] shift_new;
    logic [7:0]  need_bytes;

    // Combinational result.
    logic        res_emit;
    kind_t       res_kind;
    logic [31:0] res_addr;
    logic [7:0]  res_data;
    logic [7:0]  res_sum;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Character classification and hex pair assembly.
    assign in_record = (phase_reg == PH_COUNT) || (phase_reg == PH_ADDR) ||
                       (phase_reg == PH_TYPE) || (phase_reg == PH_DATA) ||
                       (phase_reg == PH_PAYLOAD) || (phase_reg == PH_CHECK);
    assign is_newline    = (character == CHAR_NEWLINE);
    assign decode_active = in_record && !is_newline;
    assign nib           = hex_nibble(character);
    assign cur_bad       = decode_active && !hex_valid(character);
    assign cur_byte      = {high_nibble_reg, nib};
    assign calc_sum      = 8'(8'd0 - running_sum_reg);
    assign index_inc     = 8'(byte_index_reg + 8'd1);
    assign shift_new     = {payload_shift_reg[23:0], cur_byte};
    assign need_bytes    = (rec_kind_reg == REC_EXT_LINEAR) ? EXT_BYTES : START_BYTES;

    // Next-state logic.
    always_comb
    begin
        phase_next         = phase_reg;
        high_nibble_next   = high_nibble_reg;
        digit_half_next    = digit_half_reg;
        byte_count_next    = byte_count_reg;
        rec_kind_next      = rec_kind_reg;
        load_addr_next     = load_addr_reg;
        byte_index_next    = byte_index_reg;
        base_upper_next    = base_upper_reg;
        running_sum_next   = running_sum_reg;
        payload_shift_next = payload_shift_reg;
        start_addr_next    = start_addr_reg;
        start_seen_next    = start_seen_reg;
        bad_hex_seen_next  = bad_hex_seen_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_DONE, PH_STOPPED:
                begin
                end
                PH_SKIP:
                begin
                    if (is_newline)
                    begin
                        phase_next = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (character == CHAR_COLON)
                    begin
                        phase_next         = PH_COUNT;
                        digit_half_next    = 1'b0;
                        high_nibble_next   = 4'd0;
                        running_sum_next   = 8'd0;
                        byte_index_next    = 8'd0;
                        load_addr_next     = 16'd0;
                        payload_shift_next = 32'd0;
                    end
                    else
                    begin
                        phase_next = PH_STOPPED;
                    end
                end
                PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_PAYLOAD, PH_CHECK:
                begin
                    if (is_newline)
                    begin
                        phase_next = PH_STOPPED;
                    end
                    else if (!digit_half_reg)
                    begin
                        high_nibble_next = nib;
                        digit_half_next  = 1'b1;
                    end
                    else if (phase_reg == PH_CHECK)
                    begin
                        digit_half_next = 1'b0;
                        if (calc_sum != cur_byte && fatal_reg)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else
                    begin
                        digit_half_next  = 1'b0;
                        running_sum_next = 8'(running_sum_reg + cur_byte);
                        unique case (phase_reg)
                            PH_COUNT:
                            begin
                                byte_count_next = cur_byte;
                                if (cur_byte == 8'd0)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    byte_index_next = 8'd0;
                                    phase_next      = PH_ADDR;
                                end
                            end
                            PH_ADDR:
                            begin
                                load_addr_next  = {load_addr_reg[7:0], cur_byte};
                                byte_index_next = index_inc;
                                if (index_inc >= ADDR_BYTES)
                                begin
                                    phase_next = PH_TYPE;
                                end
                            end
                            PH_TYPE:
                            begin
                                byte_index_next    = 8'd0;
                                payload_shift_next = 32'd0;
                                if (cur_byte == TYPE_DATA)
                                begin
                                    rec_kind_next = REC_DATA;
                                    phase_next    = PH_DATA;
                                end
                                else if (cur_byte == TYPE_EXT_LINEAR)
                                begin
                                    rec_kind_next = REC_EXT_LINEAR;
                                    phase_next    = PH_PAYLOAD;
                                end
                                else if (cur_byte == TYPE_START)
                                begin
                                    rec_kind_next = REC_START;
                                    phase_next    = PH_PAYLOAD;
                                end
                                else
                                begin
                                    phase_next = PH_STOPPED;
                                end
                            end
                            PH_DATA:
                            begin
                                byte_index_next = index_inc;
                                if (index_inc == byte_count_reg)
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            PH_PAYLOAD:
                            begin
                                payload_shift_next = shift_new;
                                byte_index_next    = index_inc;
                                if (index_inc >= need_bytes)
                                begin
                                    if (rec_kind_reg == REC_EXT_LINEAR)
                                    begin
                                        base_upper_next = shift_new[15:0];
                                    end
                                    else
                                    begin
                                        start_addr_next = shift_new;
                                        start_seen_next = 1'b1;
                                    end
                                    phase_next = PH_CHECK;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_STOPPED;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = PH_STOPPED;
                end
            endcase
            // The flag collects bad digits and is cleared by every result.
            bad_hex_seen_next = res_emit ? 1'b0 : (bad_hex_seen_reg | cur_bad);
        end
    end

    // Result decision for the current character.
    always_comb
    begin
        res_emit = 1'b0;
        res_kind = KIND_DATA;
        res_addr = 32'd0;
        res_data = 8'd0;
        res_sum  = 8'd0;
        unique case (phase_reg)
            PH_DONE, PH_STOPPED, PH_SKIP:
            begin
            end
            PH_COLON:
            begin
                if (character != CHAR_COLON)
                begin
                    res_emit = 1'b1;
                    res_kind = KIND_FORMAT;
                end
            end
            PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_PAYLOAD, PH_CHECK:
            begin
                if (is_newline)
                begin
                    res_emit = 1'b1;
                    res_kind = KIND_FORMAT;
                end
                else if (digit_half_reg)
                begin
                    unique case (phase_reg)
                        PH_CHECK:
                        begin
                            res_emit = 1'b1;
                            res_sum  = calc_sum;
                            if (calc_sum == cur_byte)
                            begin
                                res_kind = KIND_REC_OK;
                            end
                            else if (fatal_reg)
                            begin
                                res_kind = KIND_SUM_FATAL;
                            end
                            else
                            begin
                                res_kind = KIND_SUM_WARN;
                            end
                        end
                        PH_COUNT:
                        begin
                            if (cur_byte == 8'd0)
                            begin
                                res_emit = 1'b1;
                                res_kind = KIND_END;
                            end
                        end
                        PH_TYPE:
                        begin
                            if (cur_byte != TYPE_DATA && cur_byte != TYPE_EXT_LINEAR &&
                                cur_byte != TYPE_START)
                            begin
                                res_emit = 1'b1;
                                res_kind = KIND_BAD_TYPE;
                            end
                        end
                        PH_DATA:
                        begin
                            res_emit = 1'b1;
                            res_kind = KIND_DATA;
                            res_addr = {base_upper_reg, 16'd0} + {16'd0, load_addr_reg} +
                                       {24'd0, byte_index_reg};
                            res_data = cur_byte;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Parser state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_COLON;
            high_nibble_reg   <= 4'd0;
            digit_half_reg    <= 1'b0;
            byte_count_reg    <= 8'd0;
            rec_kind_reg      <= REC_DATA;
            load_addr_reg     <= 16'd0;
            byte_index_reg    <= 8'd0;
            base_upper_reg    <= 16'd0;
            running_sum_reg   <= 8'd0;
            payload_shift_reg <= 32'd0;
            start_addr_reg    <= 32'd0;
            start_seen_reg    <= 1'b0;
            bad_hex_seen_reg  <= 1'b0;
            fatal_reg         <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            high_nibble_reg   <= high_nibble_next;
            digit_half_reg    <= digit_half_next;
            byte_count_reg    <= byte_count_next;
            rec_kind_reg      <= rec_kind_next;
            load_addr_reg     <= load_addr_next;
            byte_index_reg    <= byte_index_next;
            base_upper_reg    <= base_upper_next;
            running_sum_reg   <= running_sum_next;
            payload_shift_reg <= payload_shift_next;
            start_addr_reg    <= start_addr_next;
            start_seen_reg    <= start_seen_next;
            bad_hex_seen_reg  <= bad_hex_seen_next;
            if (cfg_wr_en)
            begin
                fatal_reg <= cfg_wr_data;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && res_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (in_accept && res_emit)
        begin
            kind_reg        <= res_kind;
            address_reg     <= res_addr;
            data_reg        <= res_data;
            sum_reg         <= res_sum;
            start_out_reg   <= start_addr_reg;
            start_valid_reg <= start_seen_reg;
            bad_hex_reg     <= bad_hex_seen_reg | cur_bad;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign address       = address_reg;
    assign data_byte     = data_reg;
    assign computed_sum  = sum_reg;
    assign start_address = start_out_reg;
    assign start_valid   = start_valid_reg;
    assign bad_hex       = bad_hex_reg;

    // Once ended or stopped, the parser stays there until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STOPPED || phase_reg == PH_DONE) |=> phase_reg == $past(phase_reg))
        else $error("parser left a terminal phase");

    // A started hex pair is never carried into the colon or skip phases.
    // A newline in mid pair may leave it set in the stopped phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_half_reg |-> (phase_reg != PH_COLON && phase_reg != PH_SKIP))
        else $error("half hex pair outside a record");

    // Only data writes carry an address and a data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_DATA) |-> (address_reg == 32'd0 && data_reg == 8'd0))
        else $error("non-data result with address or data");

    // The start address flag never clears once set.
    assert property (@(posedge clk) disable iff (!rst_n)
        start_seen_reg |=> start_seen_reg)
        else $error("start address flag cleared");

endmodule

[sim/intel_hex_record_parser_core_tb.sv]
// Self-checking testbench for the Intel HEX record parser core.
`timescale 1ns / 100ps

module intel_hex_record_parser_core_tb;
    import ihex_pkg::*;

    localparam int CHAR_TARGET    = 1500;
    localparam int PHASE_CHARS    = 300;
    localparam int MAX_GAP        = 17;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    // One expected parser result.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  computed_sum;
        logic [31:0] start_address;
        logic        start_valid;
        logic        bad_hex;
    } hex_result_t;

    // Ways the stream is brought to a permanent halt at the end of the run.
    typedef enum int {
        STOP_END_RECORD,
        STOP_NO_COLON,
        STOP_EARLY_NEWLINE,
        STOP_BAD_TYPE,
        STOP_SUM_FATAL
    } stop_case_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  character;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  computed_sum;
    logic [31:0] start_address;
    logic        start_valid;
    logic        bad_hex;

    // Parser state tracked by the testbench.
    phase_t      p_phase;
    logic [3:0]  p_hi;
    logic        p_half;
    logic [7:0]  p_count;
    rec_kind_t   p_rec;
    logic [15:0] p_load;
    logic [7:0]  p_idx;
    logic [15:0] p_base;
    logic [7:0]  p_sum;
    logic [31:0] p_shift;
    logic [31:0] p_start;
    logic        p_start_seen;
    logic        p_bad;
    logic        cfg_fatal;

    hex_result_t pending_results[$];
    hex_result_t head;
    logic [7:0]  line_bytes[$];

    int  error_count;
    int  chars_sent;
    int  results_checked;
    int  kind_seen[0:7];
    bit  src_calm;
    bit  sink_calm;
    bit  hold_pending;
    string stop_label;

    intel_hex_record_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .character     (character),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .address       (address),
        .data_byte     (data_byte),
        .computed_sum  (computed_sum),
        .start_address (start_address),
        .start_valid   (start_valid),
        .bad_hex       (bad_hex)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Returns {invalid, value}; an invalid digit has value zero.
    function automatic logic [4:0] decode_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b0, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            return {1'b0, 4'(c[3:0] + 4'd9)};
        end
        return 5'b10000;
    endfunction

    // Queues one expected result; every result clears the bad-digit flag.
    function automatic void push_result(input kind_t k, input logic [31:0] a,
                                        input logic [7:0] d, input logic [7:0] s);
        hex_result_t r;
        r.kind          = k;
        r.address       = a;
        r.data_byte     = d;
        r.computed_sum  = s;
        r.start_address = p_start;
        r.start_valid   = p_start_seen;
        r.bad_hex       = p_bad;
        p_bad = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Advances the tracked parser by one accepted character.
    function automatic void parse_char(input logic [7:0] c);
        logic [4:0]  dec;
        logic [7:0]  b;
        logic [7:0]  want;
        logic [31:0] waddr;
        if (p_phase == PH_DONE || p_phase == PH_STOPPED)
        begin
            return;
        end
        if (p_phase == PH_SKIP)
        begin
            if (c == CHAR_NEWLINE)
            begin
                p_phase = PH_COLON;
            end
            return;
        end
        if (p_phase == PH_COLON)
        begin
            if (c == CHAR_COLON)
            begin
                p_phase = PH_COUNT;
                p_half  = 1'b0;
                p_hi    = 4'd0;
                p_sum   = 8'd0;
                p_idx   = 8'd0;
                p_load  = 16'd0;
                p_shift = 32'd0;
            end
            else
            begin
                p_phase = PH_STOPPED;
                push_result(KIND_FORMAT, 32'd0, 8'd0, 8'd0);
            end
            return;
        end
        // A line may not end before its checksum is complete.
        if (c == CHAR_NEWLINE)
        begin
            p_phase = PH_STOPPED;
            push_result(KIND_FORMAT, 32'd0, 8'd0, 8'd0);
            return;
        end
        dec = decode_digit(c);
        if (dec[4])
        begin
            p_bad = 1'b1;
        end
        if (!p_half)
        begin
            p_hi   = dec[3:0];
            p_half = 1'b1;
            return;
        end
        p_half = 1'b0;
        b = {p_hi, dec[3:0]};

        if (p_phase == PH_CHECK)
        begin
            want = 8'd0 - p_sum;
            if (want == b)
            begin
                p_phase = PH_SKIP;
                push_result(KIND_REC_OK, 32'd0, 8'd0, want);
            end
            else if (cfg_fatal)
            begin
                p_phase = PH_STOPPED;
                push_result(KIND_SUM_FATAL, 32'd0, 8'd0, want);
            end
            else
            begin
                p_phase = PH_SKIP;
                push_result(KIND_SUM_WARN, 32'd0, 8'd0, want);
            end
            return;
        end

        p_sum = p_sum + b;
        case (p_phase)
            PH_COUNT:
            begin
                p_count = b;
                if (b == 8'd0)
                begin
                    p_phase = PH_DONE;
                    push_result(KIND_END, 32'd0, 8'd0, 8'd0);
                end
                else
                begin
                    p_idx   = 8'd0;
                    p_phase = PH_ADDR;
                end
            end
            PH_ADDR:
            begin
                p_load = {p_load[7:0], b};
                p_idx  = p_idx + 8'd1;
                if (p_idx >= ADDR_BYTES)
                begin
                    p_phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                p_idx   = 8'd0;
                p_shift = 32'd0;
                if (b == TYPE_DATA)
                begin
                    p_rec   = REC_DATA;
                    p_phase = PH_DATA;
                end
                else if (b == TYPE_EXT_LINEAR)
                begin
                    p_rec   = REC_EXT_LINEAR;
                    p_phase = PH_PAYLOAD;
                end
                else if (b == TYPE_START)
                begin
                    p_rec   = REC_START;
                    p_phase = PH_PAYLOAD;
                end
                else
                begin
                    p_phase = PH_STOPPED;
                    push_result(KIND_BAD_TYPE, 32'd0, 8'd0, 8'd0);
                end
            end
            PH_DATA:
            begin
                waddr = {p_base, 16'h0000} + 32'(p_load) + 32'(p_idx);
                p_idx = p_idx + 8'd1;
                if (p_idx == p_count)
                begin
                    p_phase = PH_CHECK;
                end
                push_result(KIND_DATA, waddr, b, 8'd0);
            end
            PH_PAYLOAD:
            begin
                // The payload length is fixed by the type; the count is not used.
                p_shift = {p_shift[23:0], b};
                p_idx   = p_idx + 8'd1;
                if (p_idx >= ((p_rec == REC_EXT_LINEAR) ? EXT_BYTES : START_BYTES))
                begin
                    if (p_rec == REC_EXT_LINEAR)
                    begin
                        p_base = p_shift[15:0];
                    end
                    else
                    begin
                        p_start      = p_shift;
                        p_start_seen = 1'b1;
                    end
                    p_phase = PH_CHECK;
                end
            end
            default:
            begin
                p_phase = PH_STOPPED;
            end
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10)
        begin
            return 8'h30 + 8'(nib);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
    endfunction

    // Any character that is neither a hex digit nor a newline.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        logic [4:0] dec;
        do
        begin
            c   = 8'($urandom_range(0, 255));
            dec = decode_digit(c);
        end
        while (!dec[4] || c == CHAR_NEWLINE);
        return c;
    endfunction

    // Characters after the checksum: anything but a newline, colons now and then.
    function automatic logic [7:0] trail_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
        begin
            return CHAR_COLON;
        end
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == CHAR_NEWLINE);
        return c;
    endfunction

    // Sends one character word and tracks it once it is taken.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        do @(posedge clk); while (!in_ready);
        parse_char(c);
        chars_sent++;
    endtask

    // Lowers valid and waits until every expected result has been taken.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fatal(input logic value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_fatal = value;
    endtask

    task automatic start_line(input logic [7:0] count, input logic [15:0] load,
                              input logic [7:0] rtype);
        line_bytes.delete();
        line_bytes.push_back(count);
        line_bytes.push_back(load[15:8]);
        line_bytes.push_back(load[7:0]);
        line_bytes.push_back(rtype);
    endtask

    // Appends the checksum and sends the record as text. Noise swaps digits for
    // invalid characters; nonzero digits of the count and type are never touched,
    // and under a fatal checksum setting only zero digits are. A nonnegative cut
    // ends the line with a newline after that many digits.
    task automatic send_line(input bit spoil, input int noise_pct, input bit trailer,
                             input int cut_digits);
        logic [7:0] total;
        logic [3:0] nib;
        logic [7:0] c;
        int k;
        int d;
        int sent;
        total = 8'd0;
        for (k = 0; k < line_bytes.size(); k++)
        begin
            total = total + line_bytes[k];
        end
        total = 8'd0 - total;
        if (spoil)
        begin
            total = total + 8'($urandom_range(1, 255));
        end
        line_bytes.push_back(total);
        send_char(CHAR_COLON);
        sent = 0;
        for (k = 0; k < line_bytes.size(); k++)
        begin
            for (d = 0; d < 2; d++)
            begin
                if (sent == cut_digits)
                begin
                    send_char(CHAR_NEWLINE);
                    return;
                end
                nib = (d == 0) ? line_bytes[k][7:4] : line_bytes[k][3:0];
                c = digit_char(nib, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 99) < noise_pct &&
                    (nib == 4'd0 || (!cfg_fatal && k != 0 && k != 3)))
                begin
                    c = junk_char();
                end
                send_char(c);
                sent++;
            end
        end
        if (trailer)
        begin
            repeat ($urandom_range(1, 4)) send_char(trail_char());
        end
        send_char(CHAR_NEWLINE);
    endtask

    task automatic push_random_bytes(input int n);
        repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // One well-formed record with random content, occasionally spoiled.
    task automatic send_random_record();
        int r;
        int noise;
        bit spoil;
        logic [7:0]  count;
        logic [15:0] load;
        src_calm  = ($urandom_range(0, 2) == 0);
        sink_calm = ($urandom_range(0, 2) == 0);
        noise = ($urandom_range(0, 4) == 0) ? 15 : 0;
        spoil = !cfg_fatal && ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        load = ($urandom_range(0, 9) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                           : 16'($urandom_range(0, 16'hFFFF));
        if (r < 70)
        begin
            count = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(17, 255))
                                                 : 8'($urandom_range(1, 16));
            start_line(count, load, TYPE_DATA);
            push_random_bytes(count);
        end
        else if (r < 85)
        begin
            count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd2;
            start_line(count, load, TYPE_EXT_LINEAR);
            case ($urandom_range(0, 3))
                0:
                begin
                    line_bytes.push_back(8'h00);
                    line_bytes.push_back(8'h00);
                end
                1:
                begin
                    line_bytes.push_back(8'hFF);
                    line_bytes.push_back(8'hFF);
                end
                default:
                begin
                    push_random_bytes(2);
                end
            endcase
        end
        else
        begin
            count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd4;
            start_line(count, load, TYPE_START);
            push_random_bytes(4);
        end
        send_line(spoil, noise, $urandom_range(0, 3) == 0, -1);
    endtask

    // Receiver: random stalls per result, calm stretches, and one long hold.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else
            begin
                if (out_valid && out_ready)
                begin
                    stall_left = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
                end
                if (stall_left > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compares each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            kind_seen[kind]++;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d", kind);
                error_count++;
            end
            else
            begin
                head = pending_results.pop_front();
                check_field("kind", 32'(head.kind), 32'(kind));
                check_field("address", head.address, address);
                check_field("data_byte", 32'(head.data_byte), 32'(data_byte));
                check_field("computed_sum", 32'(head.computed_sum), 32'(computed_sum));
                check_field("start_address", head.start_address, start_address);
                check_field("start_valid", 32'(head.start_valid), 32'(start_valid));
                check_field("bad_hex", 32'(head.bad_hex), 32'(bad_hex));
            end
        end
    end

    // Ends the run when no word moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("intel_hex_record_parser_core_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic test_config_after_reset();
        write_fatal(1'b0);
    endtask

    // Upper base and load address at their top values, so the writes wrap.
    task automatic test_data_address_extremes();
        start_line(8'd2, 16'h0000, TYPE_EXT_LINEAR);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(8'hFF);
        send_line(1'b0, 0, 1'b0, -1);
        start_line(8'd2, 16'hFFFF, TYPE_DATA);
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        send_line(1'b0, 0, 1'b0, -1);
        start_line(8'd2, 16'h0000, TYPE_EXT_LINEAR);
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'h00);
        send_line(1'b0, 0, 1'b0, -1);
    endtask

    // A start address and an extended linear record, with byte counts that do not match the payload.
    task automatic test_start_address_capture();
        start_line(8'd1, 16'h1234, TYPE_START);
        repeat (4) line_bytes.push_back(8'hFF);
        send_line(1'b0, 0, 1'b0, -1);
        start_line(8'd9, 16'h0000, TYPE_EXT_LINEAR);
        push_random_bytes(2);
        send_line(1'b0, 0, 1'b0, -1);
        start_line(8'd1, 16'h0010, TYPE_DATA);
        push_random_bytes(1);
        send_line(1'b0, 0, 1'b0, -1);
    endtask

    // A wrong checksum with the fatal setting off is reported as a warning, and parsing goes on.
    task automatic test_checksum_reported();
        start_line(8'd3, 16'h0100, TYPE_DATA);
        push_random_bytes(3);
        send_line(1'b1, 0, 1'b0, -1);
        start_line(8'd1, 16'h0200, TYPE_DATA);
        push_random_bytes(1);
        send_line(1'b0, 0, 1'b0, -1);
    endtask

    task automatic test_invalid_digits();
        start_line(8'd4, 16'h0300, TYPE_DATA);
        push_random_bytes(4);
        send_line(1'b0, 100, 1'b0, -1);
    endtask

    task automatic test_trailing_characters();
        start_line(8'd2, 16'h0400, TYPE_DATA);
        push_random_bytes(2);
        send_line(1'b0, 0, 1'b1, -1);
    endtask

    // The receiver holds off while records keep coming, so the input stalls.
    task automatic test_output_hold();
        wait_idle();
        src_calm = 1'b1;
        hold_pending = 1'b1;
        repeat (3)
        begin
            start_line(8'd8, 16'($urandom_range(0, 16'hFFFF)), TYPE_DATA);
            push_random_bytes(8);
            send_line(1'b0, 0, 1'b0, -1);
        end
        src_calm = 1'b0;
        wait_idle();
    endtask

    // Random records in phases, flipping the fatal setting between phases.
    task automatic test_random_stream();
        int phase_end;
        while (chars_sent < CHAR_TARGET)
        begin
            write_fatal(~cfg_fatal);
            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end)
            begin
                send_random_record();
            end
        end
    endtask

    // Only one halting case fits in a run; the seed picks which one.
    task automatic test_stop_case();
        stop_case_t pick;
        logic [7:0] count;
        logic [7:0] rtype;
        logic [7:0] lead;
        pick = stop_case_t'($urandom_range(0, 4));
        stop_label = pick.name();
        src_calm = 1'b0;
        sink_calm = 1'b0;
        count = 8'($urandom_range(1, 8));
        case (pick)
            STOP_END_RECORD:
            begin
                start_line(8'd0, 16'($urandom_range(0, 16'hFFFF)), TYPE_DATA);
                send_line(1'b0, 0, 1'b0, -1);
            end
            STOP_NO_COLON:
            begin
                // The line must open with something other than a colon.
                do
                begin
                    lead = junk_char();
                end
                while (lead == CHAR_COLON);
                send_char(($urandom_range(0, 1) == 0) ? CHAR_NEWLINE : lead);
            end
            STOP_EARLY_NEWLINE:
            begin
                start_line(count, 16'($urandom_range(0, 16'hFFFF)), TYPE_DATA);
                push_random_bytes(count);
                send_line(1'b0, 0, 1'b0, $urandom_range(0, 2 * (int'(count) + 5) - 1));
            end
            STOP_BAD_TYPE:
            begin
                do
                begin
                    rtype = 8'($urandom_range(0, 255));
                end
                while (rtype == TYPE_DATA || rtype == TYPE_EXT_LINEAR || rtype == TYPE_START);
                start_line(count, 16'($urandom_range(0, 16'hFFFF)), rtype);
                push_random_bytes(count);
                send_line(1'b0, 0, 1'b0, -1);
            end
            default:
            begin
                write_fatal(1'b1);
                start_line(count, 16'($urandom_range(0, 16'hFFFF)), TYPE_DATA);
                push_random_bytes(count);
                send_line(1'b1, 0, 1'b0, -1);
            end
        endcase
        // Everything after the halt is taken but gives no result.
        start_line(8'd2, 16'h0000, TYPE_DATA);
        push_random_bytes(2);
        send_line(1'b0, 0, 1'b0, -1);
        repeat (12) send_char(trail_char());
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        in_valid     = 1'b0;
        character    = 8'd0;
        error_count  = 0;
        chars_sent   = 0;
        results_checked = 0;
        src_calm     = 1'b0;
        sink_calm    = 1'b0;
        hold_pending = 1'b0;
        stop_label   = "";
        for (int i = 0; i < 8; i++)
        begin
            kind_seen[i] = 0;
        end
        p_phase      = PH_COLON;
        p_hi         = 4'd0;
        p_half       = 1'b0;
        p_count      = 8'd0;
        p_rec        = REC_DATA;
        p_load       = 16'd0;
        p_idx        = 8'd0;
        p_base       = 16'd0;
        p_sum        = 8'd0;
        p_shift      = 32'd0;
        p_start      = 32'd0;
        p_start_seen = 1'b0;
        p_bad        = 1'b0;
        cfg_fatal    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_config_after_reset();
        test_data_address_extremes();
        test_start_address_capture();
        test_checksum_reported();
        test_invalid_digits();
        test_trailing_characters();
        test_output_hold();
        test_random_stream();
        test_stop_case();
        wait_idle();

        $display("Run covered %0d characters and %0d results: %0d byte writes, %0d good records,",
                 chars_sent, results_checked, kind_seen[KIND_DATA], kind_seen[KIND_REC_OK]);
        $display("%0d reported checksum errors; the stream was halted by %s.",
                 kind_seen[KIND_SUM_WARN], stop_label);
        if (error_count == 0)
        begin
            $display("intel_hex_record_parser_core_tb: done, clean");
        end
        else
        begin
            $display("intel_hex_record_parser_core_tb: done, errors");
        end
        $finish;
    end

endmodule
